### rtl/ssc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types and constants for the subset sum counter: widths, the
// modulus, controller states and the command/status groups.
// ----------------------------------------------------------------------------
package ssc_pkg;

  // field widths
  localparam int ELEM_W  = 16;
  localparam int TGT_W   = 10;
  localparam int WAYS_W  = 30;

  // default table size limit
  localparam int MAX_SUM_DEF = 1023;

  // counts are kept modulo this prime
  localparam logic [WAYS_W-1:0] MOD_P = 30'd1000000007;

  // controller states
  typedef enum logic [2:0] {
    ST_INIT,   // sweep after reset
    ST_IDLE,   // waiting for an item
    ST_DISP,   // decide what the captured item needs
    ST_CLR,    // sweep before a first item
    ST_UPD,    // one table entry per cycle, high sum downward
    ST_FLUSH,  // last write of the update lands
    ST_RD,     // read the count at the target
    ST_OUT     // hand the count to the output register
  } ssc_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the input item
    logic clr_init;  // point the address counter at entry zero
    logic clr_wr;    // write one cleared entry, step upward
    logic upd_init;  // point the address counter at the target
    logic upd_rd;    // read one entry pair, step downward
    logic out_load;  // move the target count to the output register
  } ssc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;  // sweep is at the last entry
    logic upd_last;  // update is at the element value
    logic skip;      // element above target, nothing to update
    logic first;     // captured item starts a new array
    logic out_busy;  // output register holds an item not taken this cycle
  } ssc_sts_t;

endpackage

### rtl/subset_sum_count_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subset_sum_count_mod
// Counts subsets of a stream of elements summing to a configured target,
// modulo 1000000007, with one table entry per partial sum.
// ----------------------------------------------------------------------------
// One item at a time. An item with element e and effective target t passes
// from acceptance through dispatch, the update pass over entries t down to e,
// a flush, a table read and the output load when e <= t; when e > t the update
// pass and flush are skipped. The update pass walks the count table one entry
// per cycle through a memory with two read ports and one write port. An item
// with tuser set first sweeps the whole table. After reset the same sweep runs
// with in_tready low; configuration writes are taken at any time. A result
// waiting in the output register and not taken holds off the next item.
module subset_sum_count_mod #(
  parameter int MAX_SUM = ssc_pkg::MAX_SUM_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_wr_en,
  input  logic [ssc_pkg::TGT_W-1:0]  cfg_wr_data,   // target_sum
  // input items
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [15:0]                in_tdata,      // [15:0] element
  input  logic                       in_tuser,      // [0] first
  // result items
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [31:0]                out_tdata      // [29:0] ways, [31:30] zero
);
  import ssc_pkg::*;

  ssc_cmd_t          cmd;
  ssc_sts_t          sts;
  logic [WAYS_W-1:0] ways;

  // sequencer
  ssc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // table and arithmetic
  ssc_dpath #(
    .MAX_SUM (MAX_SUM)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_elem     (in_tdata[ELEM_W-1:0]),
    .in_first    (in_tuser),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_ways    (ways),
    .cmd         (cmd),
    .sts         (sts)
  );

  assign out_tdata = {2'b00, ways};

`ifndef SYNTHESIS
  // one item in flight: no second accept right behind the first
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("item accepted while previous item in work");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !sts.out_busy)
    else $error("output register overwritten before it was taken");

  // results stay reduced
  a_ways_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[29:0] < MOD_P))
    else $error("result not reduced modulo the prime");

  // sweeps and update reads never overlap
  a_excl_ops: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr_wr && cmd.upd_rd))
    else $error("clear sweep and update pass active together");
`endif

endmodule

### rtl/ssc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_ctrl
// Sequencer for the subset sum counter: clear sweeps, the downward update
// pass over the table and the read-out of the target count.
// ----------------------------------------------------------------------------
module ssc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  ssc_pkg::ssc_sts_t sts,
  output ssc_pkg::ssc_cmd_t cmd
);
  import ssc_pkg::*;

  ssc_state_t state_r;
  ssc_state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_INIT: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DISP;
        end
      end
      ST_DISP: begin
        if (sts.first) begin
          cmd.clr_init = 1'b1;
          state_nxt    = ST_CLR;
        end else if (sts.skip) begin
          state_nxt = ST_RD;
        end else begin
          cmd.upd_init = 1'b1;
          state_nxt    = ST_UPD;
        end
      end
      ST_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          if (sts.skip) begin
            state_nxt = ST_RD;
          end else begin
            cmd.upd_init = 1'b1;
            state_nxt    = ST_UPD;
          end
        end
      end
      ST_UPD: begin
        cmd.upd_rd = 1'b1;
        if (sts.upd_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_nxt = ST_RD;
      end
      ST_RD: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

endmodule

### rtl/ssc_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_dpath
// Count table memory with two read ports and one write port, the address
// counter, the modular add stage, the target register and the output
// register.
// ----------------------------------------------------------------------------
module ssc_dpath #(
  parameter int MAX_SUM = ssc_pkg::MAX_SUM_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [ssc_pkg::TGT_W-1:0]   cfg_wr_data,
  input  logic [ssc_pkg::ELEM_W-1:0]  in_elem,
  input  logic                        in_first,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ssc_pkg::WAYS_W-1:0]  out_ways,
  input  ssc_pkg::ssc_cmd_t           cmd,
  output ssc_pkg::ssc_sts_t           sts
);
  import ssc_pkg::*;

  localparam int DEPTH = MAX_SUM + 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // count table
  logic [WAYS_W-1:0] cnt_mem_r [DEPTH];

  logic [TGT_W-1:0]  tgt_r;
  logic [AW-1:0]     elem_r;
  logic              first_r;
  logic              skip_r;
  logic [AW-1:0]     t_r;
  logic [AW-1:0]     a_r;
  logic [AW-1:0]     a_nxt;
  logic              wv_r;
  logic [AW-1:0]     wa_r;
  logic [WAYS_W-1:0] rda_r;
  logic [WAYS_W-1:0] rdb_r;
  logic              out_valid_r;
  logic [WAYS_W-1:0] out_data_r;

  logic [AW-1:0]     eff_t;
  logic              sat;
  logic              skip_in;
  logic [AW-1:0]     e_lo;
  logic [AW-1:0]     rda_addr;
  logic [AW-1:0]     rdb_addr;
  logic [WAYS_W:0]   sum;
  logic [WAYS_W-1:0] wr_mod;
  logic [WAYS_W-1:0] clr_val;

  // target register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r <= '0;
    end else if (cfg_wr_en) begin
      tgt_r <= cfg_wr_data;
    end
  end

  // effective target saturates at the table top
  always_comb begin
    sat     = 17'(tgt_r) > 17'(MAX_SUM);
    eff_t   = sat ? AW'(MAX_SUM) : AW'(tgt_r);
    skip_in = 17'(in_elem) > 17'(eff_t);
  end

  // item capture, element only needed when it fits the table
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      elem_r  <= AW'(in_elem);
      first_r <= in_first;
      skip_r  <= skip_in;
      t_r     <= eff_t;
    end
  end

  assign e_lo = elem_r;

  // address counter: up for sweeps, down for updates
  always_comb begin
    a_nxt = a_r;
    if (cmd.clr_init) begin
      a_nxt = '0;
    end else if (cmd.upd_init) begin
      a_nxt = t_r;
    end else if (cmd.clr_wr) begin
      a_nxt = a_r + AW'(1);
    end else if (cmd.upd_rd) begin
      a_nxt = a_r - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r  <= '0;
      wv_r <= 1'b0;
    end else begin
      a_r  <= a_nxt;
      wv_r <= cmd.upd_rd;
    end
  end

  always_ff @(posedge clk) begin
    wa_r <= a_r;
  end

  // read addresses: port a reads entry s during updates and the target otherwise, port b reads entry s - e
  assign rda_addr = cmd.upd_rd ? a_r : t_r;
  assign rdb_addr = a_r - e_lo;

  // modular add of the entry pair
  always_comb begin
    sum    = {1'b0, rda_r} + {1'b0, rdb_r};
    wr_mod = (sum >= {1'b0, MOD_P}) ? WAYS_W'(sum - {1'b0, MOD_P}) : sum[WAYS_W-1:0];
  end

  assign clr_val = (a_r == '0) ? WAYS_W'(1) : '0;

  // table memory
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      cnt_mem_r[a_r] <= clr_val;
    end else if (wv_r) begin
      cnt_mem_r[wa_r] <= wr_mod;
    end
    rda_r <= cnt_mem_r[rda_addr];
    rdb_r <= cnt_mem_r[rdb_addr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= rda_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_ways  = out_data_r;

  // status back to the controller
  always_comb begin
    sts.clr_last = (a_r == AW'(MAX_SUM));
    sts.upd_last = (a_r == e_lo);
    sts.skip     = skip_r;
    sts.first    = first_r;
    sts.out_busy = out_valid_r && !out_ready;
  end

endmodule

### tb/sv/subset_sum_count_mod_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subset_sum_count_mod_tb
// Self-checking bench for the subset sum counter. A short table of hand-picked
// items (reset table, zero and oversized elements, extreme targets, target
// changes inside an array) is followed by random arrays over a range of
// targets. Each item is run through a local copy of the count table, and
// every result is compared with the oldest expected count. Both stream sides
// insert random gaps.
// ----------------------------------------------------------------------------
module subset_sum_count_mod_tb;
  import ssc_pkg::*;

  localparam int MAX_SUM   = MAX_SUM_DEF;
  localparam int ITEM_GOAL = 580;
  localparam int NUM_DIR   = 20;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [TGT_W-1:0]  cfg_wr_data;
  logic              in_tvalid;
  logic              in_tready;
  logic [15:0]       in_tdata;    // [15:0] element
  logic              in_tuser;    // [0] first
  logic              out_tvalid;
  logic              out_tready;
  logic [31:0]       out_tdata;   // [29:0] ways, [31:30] zero

  // table row: optional target write, then one item with an optional fixed count
  typedef struct packed {
    logic              set_tgt;
    logic [TGT_W-1:0]  tgt;
    logic [ELEM_W-1:0] elem;
    logic              first;
    logic              has_ways;
    logic [WAYS_W-1:0] ways;
  } dir_row_t;

  // set    target     element     first  fixed  ways
  dir_row_t dir_rows [NUM_DIR] = '{
    '{1'b1, 10'd0,    16'h0000,   1'b0,  1'b1,  30'd2},  // zero on the reset table
    '{1'b0, 10'd0,    16'd5,      1'b0,  1'b1,  30'd2},  // element above target
    '{1'b0, 10'd0,    16'hFFFF,   1'b1,  1'b1,  30'd1},  // new array, largest element
    '{1'b0, 10'd0,    16'h0000,   1'b1,  1'b1,  30'd2},
    '{1'b1, 10'd1023, 16'd1023,   1'b1,  1'b1,  30'd1},  // largest target
    '{1'b0, 10'd0,    16'h0000,   1'b0,  1'b1,  30'd2},  // zero doubles the whole table
    '{1'b0, 10'd0,    16'd1024,   1'b0,  1'b1,  30'd2},
    '{1'b0, 10'd0,    16'd1,      1'b0,  1'b0,  30'd0},
    '{1'b1, 10'd10,   16'd3,      1'b1,  1'b1,  30'd0},
    '{1'b0, 10'd0,    16'd7,      1'b0,  1'b1,  30'd1},
    '{1'b0, 10'd0,    16'd10,     1'b0,  1'b1,  30'd2},  // element equal to target
    '{1'b0, 10'd0,    16'h0000,   1'b0,  1'b1,  30'd4},
    '{1'b0, 10'd0,    16'd11,     1'b0,  1'b1,  30'd4},
    '{1'b1, 10'd5,    16'd2,      1'b0,  1'b0,  30'd0},  // target lowered mid-array
    '{1'b1, 10'd12,   16'd1,      1'b0,  1'b0,  30'd0},  // raised again, stale upper entries
    '{1'b0, 10'd0,    16'd12,     1'b0,  1'b0,  30'd0},
    '{1'b1, 10'd1,    16'd1,      1'b1,  1'b1,  30'd1},
    '{1'b0, 10'd0,    16'd1,      1'b0,  1'b1,  30'd2},
    '{1'b0, 10'd0,    16'h8000,   1'b0,  1'b1,  30'd2},
    '{1'b0, 10'd0,    16'hAAAA,   1'b1,  1'b1,  30'd0}
  };

  // local copy of the count table and target
  logic [WAYS_W-1:0] sum_counts [0:MAX_SUM];
  logic [TGT_W-1:0]  tgt_sum;

  logic [WAYS_W-1:0] ways_expected [$];
  int                mismatches = 0;
  int                items_sent = 0;
  int                in_calm    = 0;
  int                out_calm   = 0;

  subset_sum_count_mod #(
    .MAX_SUM(MAX_SUM)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // empty subset only
  function automatic void clear_counts();
    foreach (sum_counts[i]) sum_counts[i] = '0;
    sum_counts[0] = WAYS_W'(1);
  endfunction

  // apply one element to the table, return the count at the target
  function automatic logic [WAYS_W-1:0] apply_element(input logic [ELEM_W-1:0] elem,
                                                      input logic first);
    int            t;
    int            e;
    logic [WAYS_W:0] acc;
    t = int'(tgt_sum);
    if (t > MAX_SUM) t = MAX_SUM;
    e = int'(elem);
    if (first) clear_counts();
    // high sum downward so each entry still sees the old lower entries
    if (e <= t) begin
      for (int s = t; s >= e; s--) begin
        acc = {1'b0, sum_counts[s]} + {1'b0, sum_counts[s - e]};
        if (acc >= {1'b0, MOD_P}) acc = acc - {1'b0, MOD_P};
        sum_counts[s] = acc[WAYS_W-1:0];
      end
    end
    return sum_counts[t];
  endfunction

  // gap before the next item, with runs of back-to-back items
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // drive one item and wait for it to be taken
  task automatic send_item(input logic [ELEM_W-1:0] elem, input logic first,
                           input logic has_ways, input logic [WAYS_W-1:0] ways);
    int                gap;
    logic [WAYS_W-1:0] pred;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= elem;
    in_tuser  <= first;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = apply_element(elem, first);
    ways_expected.push_back(has_ways ? ways : pred);
    items_sent++;
  endtask

  // target write once every count is out and the controller is idle
  task automatic set_target(input logic [TGT_W-1:0] value);
    in_tvalid <= 1'b0;
    while (ways_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tgt_sum = value;
  endtask

  // result side: random stalls
  initial begin : ways_sink
    int gap;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = draw_gap(out_calm);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // compare every taken count with the oldest expected one
  always @(posedge clk) begin : check_ways
    logic [WAYS_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (ways_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected item, ways %0d", out_tdata[WAYS_W-1:0]));
      end else begin
        want = ways_expected.pop_front();
        if (out_tdata[WAYS_W-1:0] !== want)
          report_mismatch($sformatf("ways %0d, expected %0d",
                                    out_tdata[WAYS_W-1:0], want));
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int                tgt;
    int                pick;
    int                n_arr;
    int                len;
    int                zero_cut;
    int                phase;
    logic              big;
    logic              zero_heavy;
    logic              keep_table;
    logic              first;
    logic [ELEM_W-1:0] elem;

    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    clear_counts();
    tgt_sum = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // hand-picked cases
    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_tgt) set_target(dir_rows[i].tgt);
      send_item(dir_rows[i].elem, dir_rows[i].first, dir_rows[i].has_ways,
                dir_rows[i].ways);
    end

    // random arrays, one target per phase
    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      pick       = $urandom_range(0, 15);
      big        = 1'b0;
      zero_heavy = (phase == 0) || (pick == 0);
      if (zero_heavy) begin
        // long runs of zeros push the counts past the modulus
        tgt = $urandom_range(0, 3);
      end else if (pick == 1) begin
        tgt = ($urandom_range(0, 1) == 1) ? MAX_SUM : $urandom_range(512, MAX_SUM);
        big = 1'b1;
      end else if (pick <= 4) begin
        tgt = $urandom_range(65, 255);
      end else begin
        tgt = $urandom_range(1, 64);
      end
      set_target(TGT_W'(tgt));
      // sometimes carry the old table across the target change
      keep_table = (phase != 0) && ($urandom_range(0, 3) == 0);
      n_arr      = big ? 1 : $urandom_range(1, 4);
      zero_cut   = zero_heavy ? 14 : 2;
      for (int a = 0; a < n_arr && items_sent < ITEM_GOAL; a++) begin
        if (zero_heavy) len = $urandom_range(36, 48);
        else if (big)   len = $urandom_range(1, 16);
        else            len = $urandom_range(1, 40);
        for (int k = 0; k < len && items_sent < ITEM_GOAL; k++) begin
          first = ((k == 0) && !(keep_table && (a == 0))) || ($urandom_range(0, 49) == 0);
          pick  = $urandom_range(0, 19);
          if (pick <= zero_cut)
            elem = '0;
          else if (pick <= zero_cut + 2)
            elem = ELEM_W'($urandom_range(tgt + 1, 65535));
          else if (pick == zero_cut + 3)
            elem = ELEM_W'($urandom_range(0, 65535));
          else if (pick == zero_cut + 4)
            elem = ELEM_W'($urandom_range(tgt / 2, tgt));
          else
            elem = ELEM_W'($urandom_range(1, tgt / 4 + 1));
          send_item(elem, first, 1'b0, '0);
        end
      end
      phase++;
    end

    // drain, then watch for stray items
    in_tvalid <= 1'b0;
    while (ways_expected.size() != 0) @(posedge clk);
    repeat (2 * MAX_SUM + 16) @(posedge clk);
    if (mismatches == 0) begin
      $display("subset_sum_count_mod test passed");
    end else begin
      $display("subset_sum_count_mod test failed");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #60_000_000;
    $display("subset_sum_count_mod test failed");
    $finish;
  end

endmodule

### filelist.f
rtl/ssc_pkg.sv
rtl/ssc_ctrl.sv
rtl/ssc_dpath.sv
rtl/subset_sum_count_mod.sv
tb/sv/subset_sum_count_mod_tb.sv
